// ===== design/tpr_pkg.sv =====
// Package with the types and constants shared by the track path resampler.
package tpr_pkg;

  localparam logic [15:0] STEP_SIZE_RESET = 16'd66;
  localparam logic [15:0] LOW_THRESHOLD_RESET = 16'd6554;
  localparam logic [15:0] HIGH_THRESHOLD_RESET = 16'd58982;
  localparam int QUOT_WIDTH = 17;
  localparam logic [16:0] FRACTION_ONE = 17'h10000;

  typedef enum logic [1:0] {
    REG_STEP_SIZE = 2'd0,
    REG_LOW_THRESHOLD = 2'd1,
    REG_HIGH_THRESHOLD = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_VX,
    ST_MUL_VY,
    ST_COMPARE,
    ST_DIVIDE,
    ST_MUL_XL,
    ST_MUL_XH,
    ST_MUL_YL,
    ST_MUL_YH,
    ST_SUM_Y,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic first_sample;
    logic [31:0] sample_time;
    logic signed [23:0] velocity_x;
    logic signed [23:0] velocity_y;
    logic [15:0] track_fraction;
  } in_t;

  typedef struct packed {
    logic signed [47:0] point_x;
    logic signed [47:0] point_y;
    logic [31:0] point_number;
    logic signed [15:0] segment_lap;
  } out_t;

endpackage

// ===== design/track_path_resampler.sv =====
// Top level of the track path resampler with its sequencer and state.
// A sample that emits no point skips the interpolation, a sample whose
// interpolation fraction is plainly zero or one skips the divider, and the
// rest pass through the divider. A shared multiplier is used six times and
// the divider yields the 17-bit fraction. A first sample goes straight to the
// finish step. The block takes one transaction at a time. A finished point waits
// in an output register, and a later point is held back until that register has been read.
module track_path_resampler import tpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  state_t state, state_next;
  in_t    item;

  logic [15:0] step_size, low_threshold, high_threshold;

  logic [31:0]        previous_time;
  logic signed [23:0] previous_vel_x, previous_vel_y;
  logic signed [47:0] position_x, position_y;
  logic [15:0]        previous_fraction;
  logic signed [15:0] lap_number, current_segment, new_lap;
  logic [31:0]        next_target, point_counter;

  logic signed [47:0] dx, dy;
  logic [16:0]        frac;
  logic               emit;
  logic signed [63:0] acc, acc_x, acc_y;

  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic               div_start, div_done;
  logic [16:0]        div_q;

  logic [31:0]        dt;
  logic signed [24:0] vsum_x, vsum_y;
  logic signed [15:0] lap_calc;
  logic signed [31:0] cur, prev;
  logic signed [32:0] num, den;
  logic               den_le0, num_le0, space;

  assign dt = item.sample_time - previous_time;
  assign vsum_x = 25'(previous_vel_x) + 25'(item.velocity_x);
  assign vsum_y = 25'(previous_vel_y) + 25'(item.velocity_y);

  always_comb begin
    lap_calc = lap_number;
    if (item.track_fraction < low_threshold && previous_fraction > high_threshold) begin
      lap_calc = lap_number + 16'sd1;
    end else if (item.track_fraction > high_threshold &&
                 previous_fraction < low_threshold) begin
      lap_calc = lap_number - 16'sd1;
    end
  end

  assign cur = {lap_calc, item.track_fraction};
  assign prev = {lap_number, previous_fraction};
  assign num = 33'($signed(next_target)) - 33'(prev);
  assign den = 33'(cur) - 33'(prev);
  assign den_le0 = den[32] || den == 33'sd0;
  assign num_le0 = num[32] || num == 33'sd0;
  assign space = !out_valid || out_ready;

  tpr_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  tpr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({1'b0, num}),
    .den   (den),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = in_data.first_sample ? ST_FINISH : ST_MUL_VX;
        end
      end
      ST_MUL_VX: state_next = ST_MUL_VY;
      ST_MUL_VY: state_next = ST_COMPARE;
      ST_COMPARE: begin
        priority if ($signed(cur) < $signed(next_target)) begin
          state_next = ST_FINISH;
        end else if (den_le0 || num_le0) begin
          state_next = ST_MUL_XL;
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: state_next = div_done ? ST_MUL_XL : ST_DIVIDE;
      ST_MUL_XL: state_next = ST_MUL_XH;
      ST_MUL_XH: state_next = ST_MUL_YL;
      ST_MUL_YL: state_next = ST_MUL_YH;
      ST_MUL_YH: state_next = ST_SUM_Y;
      ST_SUM_Y: state_next = ST_FINISH;
      ST_FINISH: begin
        state_next = (emit && !item.first_sample && !space) ? ST_FINISH : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    div_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_MUL_VX: begin
        mul_a = 33'(vsum_x);
        mul_b = {1'b0, dt};
      end
      ST_MUL_VY: begin
        mul_a = 33'(vsum_y);
        mul_b = {1'b0, dt};
      end
      ST_COMPARE: begin
        div_start = $signed(cur) >= $signed(next_target) && !den_le0 && !num_le0;
      end
      ST_MUL_XL: begin
        mul_a = {10'b0, dx[22:0]};
        mul_b = {16'b0, frac};
      end
      ST_MUL_XH: begin
        mul_a = 33'($signed(dx[47:23]));
        mul_b = {16'b0, frac};
      end
      ST_MUL_YL: begin
        mul_a = {10'b0, dy[22:0]};
        mul_b = {16'b0, frac};
      end
      ST_MUL_YH: begin
        mul_a = 33'($signed(dy[47:23]));
        mul_b = {16'b0, frac};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= STEP_SIZE_RESET;
      low_threshold <= LOW_THRESHOLD_RESET;
      high_threshold <= HIGH_THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_SIZE: step_size <= cfg_data;
        REG_LOW_THRESHOLD: low_threshold <= cfg_data;
        REG_HIGH_THRESHOLD: high_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item <= in_data;
    end
    unique case (state)
      ST_MUL_VY: dx <= prod[58:11];
      ST_COMPARE: begin
        dy <= prod[58:11];
        new_lap <= lap_calc;
        emit <= $signed(cur) >= $signed(next_target);
        frac <= den_le0 ? FRACTION_ONE : 17'd0;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          frac <= div_q;
        end
      end
      ST_MUL_XH: acc <= prod;
      ST_MUL_YL: acc_x <= acc + (prod <<< 23);
      ST_MUL_YH: acc <= prod;
      ST_SUM_Y: acc_y <= acc + (prod <<< 23);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_time <= '0;
      previous_vel_x <= '0;
      previous_vel_y <= '0;
      position_x <= '0;
      position_y <= '0;
      previous_fraction <= '0;
      lap_number <= '0;
      next_target <= '0;
      point_counter <= '0;
      current_segment <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_FINISH) begin
        if (item.first_sample) begin
          previous_time <= item.sample_time;
          previous_vel_x <= '0;
          previous_vel_y <= '0;
          position_x <= '0;
          position_y <= '0;
          previous_fraction <= item.track_fraction;
          lap_number <= '0;
          next_target <= {16'b0, item.track_fraction} + {16'b0, step_size};
          point_counter <= '0;
          current_segment <= '0;
        end else if (!emit || space) begin
          if (emit) begin
            out_valid <= 1'b1;
            out_data.point_x <= position_x + acc_x[63:16];
            out_data.point_y <= position_y + acc_y[63:16];
            out_data.point_number <= point_counter;
            out_data.segment_lap <= current_segment;
            point_counter <= point_counter + 32'd1;
            if (lap_number > current_segment) begin
              current_segment <= lap_number;
            end
            next_target <= next_target + {16'b0, step_size};
          end
          previous_time <= item.sample_time;
          previous_vel_x <= item.velocity_x;
          previous_vel_y <= item.velocity_y;
          position_x <= position_x + dx;
          position_y <= position_y + dy;
          previous_fraction <= item.track_fraction;
          lap_number <= new_lap;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_frac_bound: assert property (@(posedge clk) disable iff (rst)
    div_done |-> div_q <= FRACTION_ONE)
    else $error("Interpolation fraction exceeds one.");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("Result appeared outside the finish step.");

  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !item.first_sample && emit && space)
    |=> point_counter == $past(point_counter) + 32'd1)
    else $error("Point counter did not advance with a result.");
`endif

endmodule

// ===== design/tpr_mul.sv =====
// Shared signed multiplier with a registered product.
module tpr_mul import tpr_pkg::*; (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [63:0] prod
);

  logic signed [65:0] full;

  assign full = a * b;

  always_ff @(posedge clk) begin
    prod <= full[63:0];
  end

endmodule

// ===== design/tpr_div.sv =====
// Restoring divider that yields a 17-bit quotient, one bit per cycle.
module tpr_div import tpr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [33:0]           num,
  input  logic [32:0]           den,
  output logic                  done,
  output logic [QUOT_WIDTH-1:0] quot
);

  logic [33:0] rem;
  logic [32:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic        fits;
  logic [33:0] diff;

  assign fits = rem >= {1'b0, dvs};
  assign diff = rem - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(QUOT_WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dvs  <= den;
      quot <= '0;
    end else if (busy) begin
      quot <= {quot[QUOT_WIDTH-2:0], fits};
      rem  <= fits ? {diff[32:0], 1'b0} : {rem[32:0], 1'b0};
    end
  end

endmodule

// ===== tb/track_path_resampler_test.sv =====
// Testbench for the track path resampler: random and directed samples checked against a predictor.
module track_path_resampler_test;
  import tpr_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_ITEMS = 390;

  class point_board;
    out_t pending[$];
    int errors;
    logic [15:0] step_size, low_threshold, high_threshold;
    logic [31:0] prev_time, next_target, point_count;
    longint last_vx, last_vy, pos_x, pos_y;
    logic [15:0] last_frac;
    logic signed [15:0] lap, segment;

    function new();
      errors = 0;
      step_size = STEP_SIZE_RESET;
      low_threshold = LOW_THRESHOLD_RESET;
      high_threshold = HIGH_THRESHOLD_RESET;
      restart();
    endfunction

    function void restart();
      prev_time = 0;
      next_target = 0;
      point_count = 0;
      last_vx = 0;
      last_vy = 0;
      pos_x = 0;
      pos_y = 0;
      last_frac = 0;
      lap = 0;
      segment = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [15:0] value);
      case (idx)
        REG_STEP_SIZE: step_size = value;
        REG_LOW_THRESHOLD: low_threshold = value;
        REG_HIGH_THRESHOLD: high_threshold = value;
        default: ;
      endcase
    endfunction

    function longint wrap48(longint v);
      logic [47:0] t;
      t = v[47:0];
      return longint'($signed(t));
    endfunction

    function void note_sample(in_t s);
      logic [31:0] dt;
      logic signed [15:0] new_lap;
      longint dx, dy, now_pos, was_pos, tgt, num, den, f;
      out_t p;
      if (s.first_sample) begin
        restart();
        prev_time = s.sample_time;
        last_frac = s.track_fraction;
        next_target = {16'b0, s.track_fraction} + {16'b0, step_size};
        return;
      end
      dt = s.sample_time - prev_time;
      dx = wrap48(((last_vx + longint'(s.velocity_x)) * longint'({32'b0, dt})) >>> 11);
      dy = wrap48(((last_vy + longint'(s.velocity_y)) * longint'({32'b0, dt})) >>> 11);
      new_lap = lap;
      if (s.track_fraction < low_threshold && last_frac > high_threshold) begin
        new_lap = lap + 16'sd1;
      end else if (s.track_fraction > high_threshold && last_frac < low_threshold) begin
        new_lap = lap - 16'sd1;
      end
      now_pos = longint'($signed({new_lap, s.track_fraction}));
      was_pos = longint'($signed({lap, last_frac}));
      tgt = longint'($signed(next_target));
      if (now_pos >= tgt) begin
        num = tgt - was_pos;
        den = now_pos - was_pos;
        if (den <= 0) begin
          f = 65536;
        end else if (num <= 0) begin
          f = 0;
        end else begin
          f = (num <<< 16) / den;
        end
        p.point_x = 48'(pos_x + ((dx * f) >>> 16));
        p.point_y = 48'(pos_y + ((dy * f) >>> 16));
        p.point_number = point_count;
        p.segment_lap = segment;
        pending.push_back(p);
        point_count = point_count + 1;
        if (lap > segment) begin
          segment = lap;
        end
        next_target = next_target + {16'b0, step_size};
      end
      prev_time = s.sample_time;
      last_vx = longint'(s.velocity_x);
      last_vy = longint'(s.velocity_y);
      pos_x = wrap48(pos_x + dx);
      pos_y = wrap48(pos_y + dy);
      last_frac = s.track_fraction;
      lap = new_lap;
    endfunction

    function void check_point(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected point: x=%0d y=%0d n=%0d seg=%0d",
                   got.point_x, got.point_y, got.point_number, got.segment_lap);
        end
        return;
      end
      want = pending.pop_front();
      if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
          got.point_number !== want.point_number || got.segment_lap !== want.segment_lap) begin
        errors++;
        if (errors <= 10) begin
          $display("point mismatch: expected x=%0d y=%0d n=%0d seg=%0d, ",
                   want.point_x, want.point_y, want.point_number, want.segment_lap,
                   "got x=%0d y=%0d n=%0d seg=%0d",
                   got.point_x, got.point_y, got.point_number, got.segment_lap);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;

  point_board board = new();
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  logic [31:0] run_time;
  logic [15:0] run_frac;
  int run_dir;

  track_path_resampler DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        board.check_point(out_data);
      end
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        if (!rst && out_valid && out_ready) begin
          board.check_point(out_data);
        end
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
      end
    end
  end

  function automatic in_t sample(bit first, logic [31:0] t, logic [23:0] vx, logic [23:0] vy,
                                 logic [15:0] tf);
    in_t s;
    s.first_sample = first;
    s.sample_time = t;
    s.velocity_x = vx;
    s.velocity_y = vy;
    s.track_fraction = tf;
    return s;
  endfunction

  task automatic send_sample(in_t s);
    if (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 31);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    board.note_sample(s);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    board.set_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] pick_velocity();
    if ($urandom_range(9) == 0) begin
      return 24'($urandom);
    end
    return 24'($signed($urandom_range(131071)) - 65536);
  endfunction

  function automatic in_t next_sample();
    logic [31:0] adv;
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      return sample(1'($urandom_range(1)), $urandom, 24'($urandom), 24'($urandom),
                    16'($urandom));
    end
    if (pick < 14) begin
      run_time = $urandom;
      run_frac = 16'($urandom);
      run_dir = ($urandom_range(4) == 0) ? -1 : 1;
      return sample(1'b1, run_time, pick_velocity(), pick_velocity(), run_frac);
    end
    run_time = run_time + (($urandom_range(49) == 0) ? $urandom : $urandom_range(200));
    adv = $urandom_range(3 * board.step_size + 2);
    if ($urandom_range(9) == 0) begin
      adv = $urandom_range(65535);
    end
    run_frac = (run_dir > 0) ? run_frac + adv[15:0] : run_frac - adv[15:0];
    return sample(1'b0, run_time, pick_velocity(), pick_velocity(), run_frac);
  endfunction

  task automatic random_phase(int items, bit with_hold);
    for (int i = 0; i < items; i++) begin
      calm = (i >= 100 && i < 220);
      if (with_hold && i == 250) begin
        hold_req = 1'b1;
      end
      if (i == 320) begin
        wait_idle();
      end
      send_sample(next_sample());
    end
    calm = 1'b0;
    wait_idle();
  endtask

  initial begin
    run_time = 0;
    run_frac = 0;
    run_dir = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(sample(1'b0, 32'd100, 24'sd1000, -24'sd500, 16'd200));
    send_sample(sample(1'b1, 32'd0, 24'h7fffff, 24'h800000, 16'd0));
    send_sample(sample(1'b0, 32'hffffffff, 24'h7fffff, 24'h800000, 16'd65535));
    send_sample(sample(1'b1, 32'd1000, 24'd0, 24'd0, 16'd1000));
    send_sample(sample(1'b0, 32'd1100, 24'sd2560, 24'sd1280, 16'd3000));
    send_sample(sample(1'b0, 32'd1200, 24'h800000, 24'h7fffff, 16'd3100));
    send_sample(sample(1'b0, 32'd1300, 24'sd300, -24'sd300, 16'd3100));
    send_sample(sample(1'b1, 32'd5000, 24'sd100, 24'sd100, 16'd65000));
    send_sample(sample(1'b0, 32'd5050, 24'sd100, 24'sd100, 16'd100));
    send_sample(sample(1'b0, 32'd5100, -24'sd100, 24'sd100, 16'd65000));
    send_sample(sample(1'b0, 32'd5150, 24'sd100, -24'sd100, 16'd100));
    send_sample(sample(1'b0, 32'd5200, 24'sd100, 24'sd100, 16'd65535));
    send_sample(sample(1'b0, 32'd5250, 24'sd100, 24'sd100, 16'd0));
    send_sample(sample(1'b0, 32'd3, 24'sd50, 24'sd50, 16'd300));
    wait_idle();

    random_phase(PHASE_ITEMS, 1'b1);

    write_reg(REG_STEP_SIZE, 16'd1);
    write_reg(REG_LOW_THRESHOLD, 16'd0);
    write_reg(REG_HIGH_THRESHOLD, 16'd65535);
    random_phase(PHASE_ITEMS, 1'b0);

    write_reg(REG_STEP_SIZE, 16'd65535);
    write_reg(REG_LOW_THRESHOLD, 16'd65535);
    write_reg(REG_HIGH_THRESHOLD, 16'd0);
    random_phase(PHASE_ITEMS, 1'b1);

    write_reg(REG_STEP_SIZE, 16'($urandom_range(1, 2000)));
    write_reg(REG_LOW_THRESHOLD, 16'($urandom_range(20000)));
    write_reg(REG_HIGH_THRESHOLD, 16'($urandom_range(45000, 65535)));
    random_phase(PHASE_ITEMS, 1'b0);

    write_reg(REG_STEP_SIZE, STEP_SIZE_RESET);
    write_reg(REG_LOW_THRESHOLD, LOW_THRESHOLD_RESET);
    write_reg(REG_HIGH_THRESHOLD, HIGH_THRESHOLD_RESET);
    random_phase(PHASE_ITEMS, 1'b0);

    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
